>>> rtl/core/sp2c_pkg.sv
// ----------------------------------------------------------------------------
// sp2c_pkg
// Shared types and constants of the sonar polar-to-Cartesian point extractor.
// ----------------------------------------------------------------------------
package sp2c_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANG1,
        ST_ANG2,
        ST_ANG3,
        ST_ANG4,
        ST_ROT,
        ST_MUL,
        ST_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic ang1;
        logic ang2;
        logic ang3;
        logic ang4;
        logic rot;
        logic mul;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic keep;
        logic rot_last;
        logic out_free;
    } t_status;

    // stream widths
    localparam int IN_W   = 32;
    localparam int OUT_W  = 104;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTENSITY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_STRIDE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_STRIDE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_COUNT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_RESOLUTION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MODE      = 3'd5;

    // sample modes
    localparam logic [1:0] MODE_8BIT  = 2'd0;
    localparam logic [1:0] MODE_16BIT = 2'd1;

    // register reset values
    localparam logic [15:0] RST_MIN_INTENSITY    = 16'd32;
    localparam logic [7:0]  RST_RANGE_STRIDE     = 8'd4;
    localparam logic [7:0]  RST_BEAM_STRIDE      = 8'd2;
    localparam logic [10:0] RST_BEAM_COUNT       = 11'd256;
    localparam logic [23:0] RST_RANGE_RESOLUTION = 24'd10486;
    localparam logic [1:0]  RST_SAMPLE_MODE      = MODE_8BIT;

    // centidegrees to 2^-32 turn: round(mag * 2^32 / 36000)
    // = mag * C + floor((mag * R + RND) / DIV), with 2^27 = C * DIV + R
    localparam int unsigned ANG_DIV   = 1125;
    localparam logic [16:0] ANG_C     = 17'((64'd1 << 27) / 64'd1125);
    localparam logic [9:0]  ANG_R     = 10'((64'd1 << 27) % 64'd1125);
    localparam logic [9:0]  ANG_RND   = 10'd562;
    localparam int          ANG_SHIFT = 35;
    localparam logic [24:0] ANG_RECIP = 25'((64'd1 << 35) / 64'd1125);

    // cordic start value, gain-corrected unit vector in signed Q4.30
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    // arctangent of 2^-i in 2^-32 turn
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/core/sp2c_ctrl.sv
// ----------------------------------------------------------------------------
// sp2c_ctrl
// Sequencer: takes one sample, steps the datapath through angle conversion,
// cordic rotation, scaling and output load.
// ----------------------------------------------------------------------------
module sp2c_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sp2c_pkg::t_status   i_status,
    output sp2c_pkg::t_cmd      o_cmd
);

    sp2c_pkg::t_state r_state;
    sp2c_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sp2c_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sp2c_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.keep) begin
                    n_state = sp2c_pkg::ST_ANG1;
                end
            end
            sp2c_pkg::ST_ANG1: n_state = sp2c_pkg::ST_ANG2;
            sp2c_pkg::ST_ANG2: n_state = sp2c_pkg::ST_ANG3;
            sp2c_pkg::ST_ANG3: n_state = sp2c_pkg::ST_ANG4;
            sp2c_pkg::ST_ANG4: n_state = sp2c_pkg::ST_ROT;
            sp2c_pkg::ST_ROT: begin
                if (i_status.rot_last) begin
                    n_state = sp2c_pkg::ST_MUL;
                end
            end
            sp2c_pkg::ST_MUL: n_state = sp2c_pkg::ST_OUT;
            sp2c_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = sp2c_pkg::ST_IDLE;
                end
            end
            default: n_state = sp2c_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sp2c_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            sp2c_pkg::ST_ANG1: o_cmd.ang1 = 1'b1;
            sp2c_pkg::ST_ANG2: o_cmd.ang2 = 1'b1;
            sp2c_pkg::ST_ANG3: o_cmd.ang3 = 1'b1;
            sp2c_pkg::ST_ANG4: o_cmd.ang4 = 1'b1;
            sp2c_pkg::ST_ROT:  o_cmd.rot  = 1'b1;
            sp2c_pkg::ST_MUL:  o_cmd.mul  = 1'b1;
            sp2c_pkg::ST_OUT:  o_cmd.out_load = i_status.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/sp2c_dp.sv
// ----------------------------------------------------------------------------
// sp2c_dp
// Datapath: configuration registers, row and beam position counters, bearing
// to binary angle conversion, shared cordic, radius scaling and output register.
// ----------------------------------------------------------------------------
module sp2c_dp #(
    parameter int MAX_ROWS     = 4096,
    parameter int MAX_BEAMS    = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [sp2c_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sp2c_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // sample in
    input  logic [sp2c_pkg::IN_W-1:0]          i_in_data,
    input  logic                               i_in_first,
    // point out
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [sp2c_pkg::OUT_W-1:0]         o_out_data,
    // control
    input  sp2c_pkg::t_cmd                     i_cmd,
    output sp2c_pkg::t_status                  o_status
);

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int BW   = $clog2(MAX_BEAMS);
    localparam int CW   = (BW + 1 > 11) ? BW + 1 : 11;
    localparam int IW   = $clog2(CORDIC_STEPS);
    localparam int RADW = RW + 25;
    localparam int HIW  = RADW - 21;
    localparam int QW   = HIW + 33;

    // configuration registers
    logic [15:0] r_min_intensity;
    logic [7:0]  r_range_stride;
    logic [7:0]  r_beam_stride;
    logic [10:0] r_beam_count;
    logic [23:0] r_range_resolution;
    logic [1:0]  r_sample_mode;

    // position state
    logic [RW-1:0] r_rc, n_rc;
    logic [BW-1:0] r_bc, n_bc;
    logic [7:0]    r_rp, n_rp;
    logic [7:0]    r_bp, n_bp;

    // per-item registers
    logic [15:0]          r_inten;
    logic [RW-1:0]        r_row;
    logic [BW-1:0]        r_col;
    logic [15:0]          r_mag;
    logic                 r_aneg;
    logic [24:0]          r_v;
    logic [31:0]          r_tbase;
    logic [RADW-1:0]      r_radius;
    logic [14:0]          r_qe;
    logic [14:0]          r_q;
    logic                 r_flip;
    logic signed [33:0]   r_x, r_y, r_z;
    logic [IW-1:0]        r_iter;
    logic [HIW+31:0]      r_px_hi, r_py_hi;
    logic [52:0]          r_px_lo, r_py_lo;
    logic                 r_negx, r_negy;
    logic                 r_out_valid;
    logic [sp2c_pkg::OUT_W-1:0] r_out_data;

    // combinational helpers
    logic [RW-1:0]   e_rc;
    logic [BW-1:0]   e_bc;
    logic [7:0]      e_rp, e_bp;
    logic [15:0]     inten_eff;
    logic [8:0]      rs9, bs9, rp_inc, bp_inc;
    logic [CW-1:0]   nb, bc_inc;
    logic [RW:0]     rc_inc;
    logic [15:0]     raw;
    logic [24:0]     rem;
    logic [31:0]     turns, ang;
    logic            flip;
    logic signed [33:0] dx, dy, atn;
    logic [31:0]     bx, by;
    logic [31:0]     coord_x, coord_y;

    // q1 = radius * trig / 2^21, then round half away and saturate to Q16.16
    function automatic logic [31:0] sat_coord(input logic [QW-1:0] q1, input logic neg);
        logic [QW-1:0] mag;
        logic [31:0]   res;
        mag = (q1 + QW'(8192)) >> 14;
        if (neg) begin
            if (mag > QW'(33'h080000000)) begin
                mag = QW'(33'h080000000);
            end
            res = 32'd0 - mag[31:0];
        end else begin
            if (mag > QW'(32'h7FFFFFFF)) begin
                mag = QW'(32'h7FFFFFFF);
            end
            res = mag[31:0];
        end
        return res;
    endfunction

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_intensity    <= sp2c_pkg::RST_MIN_INTENSITY;
            r_range_stride     <= sp2c_pkg::RST_RANGE_STRIDE;
            r_beam_stride      <= sp2c_pkg::RST_BEAM_STRIDE;
            r_beam_count       <= sp2c_pkg::RST_BEAM_COUNT;
            r_range_resolution <= sp2c_pkg::RST_RANGE_RESOLUTION;
            r_sample_mode      <= sp2c_pkg::RST_SAMPLE_MODE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sp2c_pkg::CFG_MIN_INTENSITY:    r_min_intensity    <= i_cfg_data[15:0];
                sp2c_pkg::CFG_RANGE_STRIDE:     r_range_stride     <= i_cfg_data[7:0];
                sp2c_pkg::CFG_BEAM_STRIDE:      r_beam_stride      <= i_cfg_data[7:0];
                sp2c_pkg::CFG_BEAM_COUNT:       r_beam_count       <= i_cfg_data[10:0];
                sp2c_pkg::CFG_RANGE_RESOLUTION: r_range_resolution <= i_cfg_data[23:0];
                sp2c_pkg::CFG_SAMPLE_MODE:      r_sample_mode      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // position as seen by this sample, start of ping restarts it
    always_comb begin
        e_rc = i_in_first ? '0 : r_rc;
        e_bc = i_in_first ? '0 : r_bc;
        e_rp = i_in_first ? '0 : r_rp;
        e_bp = i_in_first ? '0 : r_bp;
        inten_eff = (r_sample_mode == sp2c_pkg::MODE_8BIT) ?
                    {8'd0, i_in_data[7:0]} : i_in_data[15:0];
    end

    // keep decision, last cordic step and output free status
    always_comb begin
        o_status.keep = ((r_sample_mode == sp2c_pkg::MODE_8BIT) ||
                         (r_sample_mode == sp2c_pkg::MODE_16BIT)) &&
                        (e_rp == 8'd0) && (e_bp == 8'd0) &&
                        (inten_eff >= r_min_intensity);
        o_status.rot_last = (r_iter == IW'(CORDIC_STEPS - 1));
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    // position advance
    always_comb begin
        rs9    = (r_range_stride == 8'd0) ? 9'd1 : {1'b0, r_range_stride};
        bs9    = (r_beam_stride == 8'd0) ? 9'd1 : {1'b0, r_beam_stride};
        nb     = (r_beam_count == 11'd0) ? CW'(1) : CW'(r_beam_count);
        if (nb > CW'(MAX_BEAMS)) begin
            nb = CW'(MAX_BEAMS);
        end
        bp_inc = {1'b0, e_bp} + 9'd1;
        rp_inc = {1'b0, e_rp} + 9'd1;
        bc_inc = CW'(e_bc) + CW'(1);
        rc_inc = {1'b0, e_rc} + (RW+1)'(1);

        n_bp = (bp_inc >= bs9) ? 8'd0 : bp_inc[7:0];
        n_bc = bc_inc[BW-1:0];
        n_rp = e_rp;
        n_rc = e_rc;
        if (bc_inc >= nb) begin
            n_bc = '0;
            n_bp = 8'd0;
            n_rp = (rp_inc >= rs9) ? 8'd0 : rp_inc[7:0];
            n_rc = rc_inc[RW-1:0];
            if (rc_inc >= (RW+1)'(MAX_ROWS)) begin
                n_rc = '0;
                n_rp = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rc <= '0;
            r_bc <= '0;
            r_rp <= 8'd0;
            r_bp <= 8'd0;
        end else if (i_cmd.load) begin
            r_rc <= n_rc;
            r_bc <= n_bc;
            r_rp <= n_rp;
            r_bp <= n_bp;
        end
    end

    // bearing magnitude and angle correction terms
    always_comb begin
        raw   = i_in_data[31:16];
        rem   = r_v - 25'(r_qe * 15'(sp2c_pkg::ANG_DIV));
        turns = r_tbase + 32'(r_q);
        ang   = r_aneg ? (32'd0 - turns) : turns;
        flip  = ang[31] ^ ang[30];
    end

    // cordic step terms
    always_comb begin
        dx  = r_y >>> r_iter;
        dy  = r_x >>> r_iter;
        atn = $signed({2'b00, sp2c_pkg::atan_turns(5'(r_iter))});
        bx  = r_x[33] ? 32'(-r_x) : 32'(r_x);
        by  = r_y[33] ? 32'(-r_y) : 32'(r_y);
    end

    // item pipeline through the sequencer steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_inten <= inten_eff;
            r_row   <= e_rc;
            r_col   <= e_bc;
            r_aneg  <= raw[15];
            r_mag   <= raw[15] ? (~raw + 16'd1) : raw;
        end
        if (i_cmd.ang1) begin
            r_v      <= 25'(r_mag * sp2c_pkg::ANG_R) + 25'(sp2c_pkg::ANG_RND);
            r_tbase  <= 32'(r_mag * sp2c_pkg::ANG_C);
            r_radius <= RADW'({r_row, 1'b1} * r_range_resolution);
        end
        if (i_cmd.ang2) begin
            r_qe <= 15'((50'(r_v) * 50'(sp2c_pkg::ANG_RECIP)) >> sp2c_pkg::ANG_SHIFT);
        end
        if (i_cmd.ang3) begin
            r_q <= (rem >= 25'(sp2c_pkg::ANG_DIV)) ? r_qe + 15'd1 : r_qe;
        end
        if (i_cmd.ang4) begin
            r_flip <= flip;
            r_z    <= 34'($signed({ang[31] ^ flip, ang[30:0]}));
            r_x    <= sp2c_pkg::CORDIC_X0;
            r_y    <= '0;
            r_iter <= '0;
        end
        if (i_cmd.rot) begin
            if (!r_z[33]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atn;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atn;
            end
            r_iter <= r_iter + IW'(1);
        end
        if (i_cmd.mul) begin
            r_px_hi <= r_radius[RADW-1:21] * bx;
            r_px_lo <= r_radius[20:0] * bx;
            r_py_hi <= r_radius[RADW-1:21] * by;
            r_py_lo <= r_radius[20:0] * by;
            // a half-turn flip negates both coordinates
            r_negx  <= r_flip ? (!r_x[33] && (r_x != '0)) : r_x[33];
            r_negy  <= r_flip ? (!r_y[33] && (r_y != '0)) : r_y[33];
        end
    end

    // rounding and saturation
    always_comb begin
        coord_x = sat_coord(QW'(r_px_hi) + QW'(r_px_lo >> 21), r_negx);
        coord_y = sat_coord(QW'(r_py_hi) + QW'(r_py_lo >> 21), r_negy);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {2'b00,
                           10'(32'(r_col)),
                           12'(32'(r_row)),
                           r_inten,
                           coord_y,
                           coord_x};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/core/sonar_polar_to_cartesian_points.sv
// Flow: a kept sample goes through the ANG1 to ANG4 angle steps, the CORDIC_STEPS rotation
// steps of the single shared cordic stage, doing one rotation step per cycle, the MUL scaling
// step and the OUT load, and no new sample is taken until its point is loaded into the output
// register; skipped samples go one per cycle while the sequencer is idle.
// Reset: synchronous active-low i_rst_n restores the register defaults and clears
// the row, beam and phase counters and the output valid.
// ----------------------------------------------------------------------------
// sonar_polar_to_cartesian_points
// Turns a raster stream of sonar samples into thresholded, decimated x/y points.
// ----------------------------------------------------------------------------
module sonar_polar_to_cartesian_points #(
    parameter int MAX_ROWS     = 4096,
    parameter int MAX_BEAMS    = 1024,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [sp2c_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sp2c_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // sample stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [sp2c_pkg::IN_W-1:0]         i_s_axis_tdata,  // intensity, bearing_centideg
    input  logic [0:0]                        i_s_axis_tuser,  // first_of_ping
    // point stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // point_x, point_y, point_intensity, row_index, column_index, 2 zero bits
    output logic [sp2c_pkg::OUT_W-1:0]        o_m_axis_tdata
);

    sp2c_pkg::t_cmd    cmd;
    sp2c_pkg::t_status status;

    sp2c_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sp2c_dp #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_BEAMS    (MAX_BEAMS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_in_first  (i_s_axis_tuser[0]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

>>> rtl/core/sp2c_chk.sv
// ----------------------------------------------------------------------------
// sp2c_chk
// Port-level checks of the point extractor, bound to the top level.
// ----------------------------------------------------------------------------
module sp2c_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [sp2c_pkg::OUT_W-1:0]       o_m_axis_tdata
);

    // a held point keeps its value until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("point changed while stalled");

    // reset clears the point stream
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("point valid after reset");

    // a point never appears in the cycle right after a sample transfer
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(i_s_axis_tvalid && o_s_axis_tready))
        else $error("point appeared too early");

    // padding bits of the point word stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[103:102] == 2'b00)
        else $error("point padding not zero");

endmodule

bind sonar_polar_to_cartesian_points sp2c_chk u_sp2c_chk (.*);
